/* hdl/ip_address_text_classifier_unit_assert.svh */
// assertion macros used by the checker of the address text classifier
`ifndef IP_ADDRESS_TEXT_CLASSIFIER_UNIT_ASSERT_SVH
`define IP_ADDRESS_TEXT_CLASSIFIER_UNIT_ASSERT_SVH

// condition in the same cycle as the trigger
`define IPATC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ipatc assertion failed");

// condition in the cycle after the trigger
`define IPATC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ipatc assertion failed");

`endif

/* hdl/ipatc_pkg.sv */
// types, codes and constants of the address text classifier
`timescale 1ns / 1ps
`default_nettype none
package ipatc_pkg;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	localparam int CHAR_W  = 8;
	localparam int COUNT_W = 4;
	localparam int LEN_W   = 3;
	localparam int VALUE_W = 10;
	localparam int DIGIT_W = 4;

	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;

	localparam logic [COUNT_W-1:0] GROUPS_V4  = 4'd4;
	localparam logic [COUNT_W-1:0] GROUPS_V6  = 4'd8;
	localparam logic [LEN_W-1:0]   V4_MAX_LEN = 3'd3;
	localparam logic [LEN_W-1:0]   V6_MAX_LEN = 3'd4;
	localparam logic [VALUE_W-1:0] V4_LIMIT   = 10'd256;

	typedef enum logic [1:0] {
		VERDICT_NONE = 2'd0,
		VERDICT_V4   = 2'd1,
		VERDICT_V6   = 2'd2
	} verdict_t;

	// one classified byte as it travels from front to back
	typedef struct packed {
		logic               colon;
		logic               dot;
		logic               dec;
		logic               hex;
		logic               zero;
		logic [DIGIT_W-1:0] digit;
		logic               last;
	} cls_t;

endpackage
`default_nettype wire

/* hdl/ipatc_char_if.sv */
// channel carrying address bytes
`timescale 1ns / 1ps
`default_nettype none
interface ipatc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

/* hdl/ipatc_verdict_if.sv */
// channel carrying classification verdicts
`timescale 1ns / 1ps
`default_nettype none
interface ipatc_verdict_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;

	modport source (output valid, output verdict, input ready);
	modport sink (input valid, input verdict, output ready);
endinterface
`default_nettype wire

/* hdl/ipatc_front.sv */
// front stage: takes a byte, decodes its class and registers it
`timescale 1ns / 1ps
`default_nettype none
module ipatc_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	ipatc_char_if.sink          chars,
	output ipatc_pkg::cls_t     cls,
	output logic                cls_valid,
	input  wire logic           cls_ready
);
	import ipatc_pkg::*;

	logic valid_s1;
	cls_t cls_s1;
	cls_t dec_cls;
	logic take;
	logic [CHAR_W-1:0] c;

	always_comb begin
		c = chars.char_code;
		dec_cls.colon = (c == CH_COLON);
		dec_cls.dot   = (c == CH_DOT);
		dec_cls.dec   = c inside {[CH_0:CH_9]};
		dec_cls.hex   = dec_cls.dec || (c inside {[CH_LA:CH_LF], [CH_UA:CH_UF]});
		dec_cls.zero  = (c == CH_0);
		dec_cls.digit = c[DIGIT_W-1:0];
		dec_cls.last  = chars.last_char;
	end

	assign chars.ready = !valid_s1 || cls_ready;
	assign take        = chars.valid && chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cls_s1 <= dec_cls;
		end
	end

	assign cls       = cls_s1;
	assign cls_valid = valid_s1;
endmodule
`default_nettype wire

/* hdl/ipatc_queue.sv */
// short queue of classified bytes between front and back
`timescale 1ns / 1ps
`default_nettype none
module ipatc_queue #(
	parameter int DEPTH = ipatc_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ipatc_pkg::cls_t  push_data,
	input  wire logic             push_valid,
	output logic                  push_ready,
	output ipatc_pkg::cls_t       pop_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready
);
	import ipatc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cls_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule
`default_nettype wire

/* hdl/ipatc_back.sv */
// back stage: running group state, verdict on the final byte, output register
`timescale 1ns / 1ps
`default_nettype none
module ipatc_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ipatc_pkg::cls_t  cls,
	input  wire logic             cls_valid,
	output logic                  cls_ready,
	ipatc_verdict_if.source       verdicts
);
	import ipatc_pkg::*;

	localparam int PROD_W = VALUE_W + 4;
	localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
	localparam logic [LEN_W-1:0]   LEN_MAX   = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	function automatic logic ok4(input logic [LEN_W-1:0] len, input logic dec,
		input logic lz, input logic [VALUE_W-1:0] val);
		ok4 = (len >= 3'd1) && (len <= V4_MAX_LEN) && dec && !((len >= 3'd2) && lz)
			&& (val < V4_LIMIT);
	endfunction

	function automatic logic ok6(input logic [LEN_W-1:0] len, input logic hex);
		ok6 = (len >= 3'd1) && (len <= V6_MAX_LEN) && hex;
	endfunction

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] cnt);
		sat_inc = (cnt == COUNT_MAX) ? cnt : cnt + 1'b1;
	endfunction

	logic               seen_colon_q, seen_dot_q;
	logic [COUNT_W-1:0] count_q;
	logic [LEN_W-1:0]   len_q;
	logic [VALUE_W-1:0] value_q;
	logic               lz_q, all_dec_q, all_hex_q, v4_ok_q, v6_ok_q;

	logic               sep;
	logic               colon_a, dot_a;
	logic [COUNT_W-1:0] count_a, count_b;
	logic [LEN_W-1:0]   len_a;
	logic [VALUE_W-1:0] value_a;
	logic [PROD_W-1:0]  prod;
	logic               lz_a, dec_a, hex_a, v4_a, v6_a, v4_b, v6_b;
	verdict_t           verdict_d;

	logic     out_valid_q;
	verdict_t verdict_q;
	logic     pop;

	always_comb begin
		sep     = cls.colon || cls.dot;
		colon_a = seen_colon_q || cls.colon;
		dot_a   = seen_dot_q || cls.dot;
		prod    = ({4'd0, value_q} << 3) + ({4'd0, value_q} << 1)
			+ {{(PROD_W-DIGIT_W){1'b0}}, cls.digit};
		if (sep) begin
			// separator closes the open group and opens an empty one
			v4_a    = v4_ok_q && ok4(len_q, all_dec_q, lz_q, value_q);
			v6_a    = v6_ok_q && ok6(len_q, all_hex_q);
			count_a = sat_inc(count_q);
			len_a   = '0;
			value_a = '0;
			lz_a    = 1'b0;
			dec_a   = 1'b1;
			hex_a   = 1'b1;
		end else begin
			v4_a    = v4_ok_q;
			v6_a    = v6_ok_q;
			count_a = count_q;
			len_a   = (len_q == LEN_MAX) ? len_q : len_q + 1'b1;
			lz_a    = (len_q == '0) ? cls.zero : lz_q;
			dec_a   = all_dec_q && cls.dec;
			hex_a   = all_hex_q && cls.hex;
			if (cls.dec) begin
				value_a = (prod > {4'd0, VALUE_MAX}) ? VALUE_MAX : prod[VALUE_W-1:0];
			end else begin
				value_a = value_q;
			end
		end
		// final byte closes whatever group is open
		v4_b    = v4_a && ok4(len_a, dec_a, lz_a, value_a);
		v6_b    = v6_a && ok6(len_a, hex_a);
		count_b = sat_inc(count_a);
		if (dot_a && !colon_a && v4_b && (count_b == GROUPS_V4)) begin
			verdict_d = VERDICT_V4;
		end else if (colon_a && !dot_a && v6_b && (count_b == GROUPS_V6)) begin
			verdict_d = VERDICT_V6;
		end else begin
			verdict_d = VERDICT_NONE;
		end
	end

	// a final byte waits only if the output register is occupied and stalled
	assign cls_ready = !cls.last || !out_valid_q || verdicts.ready;
	assign pop       = cls_valid && cls_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_colon_q <= 1'b0;
			seen_dot_q   <= 1'b0;
			count_q      <= '0;
			len_q        <= '0;
			value_q      <= '0;
			lz_q         <= 1'b0;
			all_dec_q    <= 1'b1;
			all_hex_q    <= 1'b1;
			v4_ok_q      <= 1'b1;
			v6_ok_q      <= 1'b1;
		end else if (pop) begin
			if (cls.last) begin
				seen_colon_q <= 1'b0;
				seen_dot_q   <= 1'b0;
				count_q      <= '0;
				len_q        <= '0;
				value_q      <= '0;
				lz_q         <= 1'b0;
				all_dec_q    <= 1'b1;
				all_hex_q    <= 1'b1;
				v4_ok_q      <= 1'b1;
				v6_ok_q      <= 1'b1;
			end else begin
				seen_colon_q <= colon_a;
				seen_dot_q   <= dot_a;
				count_q      <= count_a;
				len_q        <= len_a;
				value_q      <= value_a;
				lz_q         <= lz_a;
				all_dec_q    <= dec_a;
				all_hex_q    <= hex_a;
				v4_ok_q      <= v4_a;
				v6_ok_q      <= v6_a;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && cls.last) begin
			out_valid_q <= 1'b1;
		end else if (verdicts.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && cls.last) begin
			verdict_q <= verdict_d;
		end
	end

	assign verdicts.valid   = out_valid_q;
	assign verdicts.verdict = verdict_q;
endmodule
`default_nettype wire

/* hdl/ip_address_text_classifier_unit.sv */
// top level of the address text classifier
`timescale 1ns / 1ps
`default_nettype none
// Classifies an address string as IPv4, IPv6 or neither. The string arrives
// one ASCII byte per transaction on chars, with last_char set on its final
// byte; exactly one transaction with the verdict (0 neither, 1 IPv4, 2 IPv6)
// follows on verdicts for every string. Dots mean IPv4 (four groups of one to
// three decimal digits, no leading zero, value below 256), colons mean IPv6
// (eight groups of one to four hex digits); a mix of both, or neither, is
// "neither". One byte is taken every cycle, sustained, unless a held verdict
// fills the queue. The front stage decodes the byte class into a register, a
// queue of QUEUE_DEPTH entries decouples it from the back stage, which updates
// the group counters for each byte and holds the verdict in an output
// register. The final byte passes the front register and the queue before
// its verdict is registered; only the final byte of a string waits on a
// stalled verdict, so a held output stops the input only once the queue fills.
module ip_address_text_classifier_unit #(
	parameter int QUEUE_DEPTH = ipatc_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	ipatc_char_if.sink      chars,
	ipatc_verdict_if.source verdicts
);
	import ipatc_pkg::*;

	// front stage output
	cls_t front_cls;
	logic front_valid;
	logic front_ready;

	// queue output toward the back stage
	cls_t back_cls;
	logic back_valid;
	logic back_ready;

	// byte decode and input register
	ipatc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.chars     (chars),
		.cls       (front_cls),
		.cls_valid (front_valid),
		.cls_ready (front_ready)
	);

	// decoupling queue
	ipatc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (front_cls),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_data   (back_cls),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	// group tracking and verdict
	ipatc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls       (back_cls),
		.cls_valid (back_valid),
		.cls_ready (back_ready),
		.verdicts  (verdicts)
	);
endmodule
`default_nettype wire

/* hdl/ipatc_checker.sv */
// port-level checks of the address text classifier and their binding
`timescale 1ns / 1ps
`default_nettype none
`include "ip_address_text_classifier_unit_assert.svh"
module ipatc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       in_last,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] verdict
);
	import ipatc_pkg::*;

	// strings whose final byte is taken but whose verdict is not yet delivered
	logic [7:0] pending_q;
	logic       last_in;
	logic       done_out;

	assign last_in  = in_valid && in_ready && in_last;
	assign done_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (last_in && !done_out) begin
			pending_q <= pending_q + 1'b1;
		end else if (done_out && !last_in) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	`IPATC_ASSERT_NOW(a_verdict_code, clk, arst_n, out_valid, (verdict == VERDICT_NONE) || (verdict == VERDICT_V4) || (verdict == VERDICT_V6))
	`IPATC_ASSERT_NOW(a_no_invented_verdict, clk, arst_n, out_valid, pending_q != 8'd0)
	`IPATC_ASSERT_NEXT(a_stall_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(verdict))
endmodule

bind ip_address_text_classifier_unit ipatc_checker u_ipatc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (chars.valid),
	.in_ready  (chars.ready),
	.in_last   (chars.last_char),
	.out_valid (verdicts.valid),
	.out_ready (verdicts.ready),
	.verdict   (verdicts.verdict)
);
`default_nettype wire

/* verif/tb_top.sv */
// self-checking testbench of the address text classifier: directed and random address strings
`timescale 1ns / 1ps

module tb_top;
	import ipatc_pkg::*;

	// quiet cycles allowed before the run is declared hung
	localparam int WATCHDOG_LIMIT = 500;
	// random byte budgets of the mixed and the streaming phases
	localparam int RANDOM_BYTES    = 540;
	localparam int STREAMING_BYTES = 160;

	logic clk;
	logic arst_n;

	ipatc_char_if    chars_if ();
	ipatc_verdict_if verdicts_if ();

	ip_address_text_classifier_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars_if),
		.verdicts (verdicts_if)
	);

	// scan state of the string in flight, kept at the block's widths
	typedef struct {
		logic       colon_seen;
		logic       dot_seen;
		logic [3:0] groups;
		logic [2:0] len;
		logic [9:0] value;
		logic       lead_zero;
		logic       only_dec;
		logic       only_hex;
		logic       v4_ok;
		logic       v6_ok;
	} addr_scan_t;

	addr_scan_t  scan;
	verdict_t    pending_verdicts[$];
	logic [7:0]  text_buf[$];

	int unsigned error_count;
	int unsigned bytes_sent;
	int unsigned strings_sent;
	int unsigned verdicts_checked;
	int unsigned v4_hits;
	int unsigned v6_hits;
	int unsigned quiet_cycles;
	int unsigned stall_left;
	bit          idle_on;

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// predictor: tracks the open group and the running verdict per scheme
	// ------------------------------------------------------------------

	function automatic void start_group();
		scan.len       = '0;
		scan.value     = '0;
		scan.lead_zero = 1'b0;
		scan.only_dec  = 1'b1;
		scan.only_hex  = 1'b1;
	endfunction

	function automatic void clear_scan();
		scan.colon_seen = 1'b0;
		scan.dot_seen   = 1'b0;
		scan.groups     = '0;
		scan.v4_ok      = 1'b1;
		scan.v6_ok      = 1'b1;
		start_group();
	endfunction

	// a separator or the end of the string judges the open group
	function automatic void close_group();
		logic fits_v4;
		logic fits_v6;
		fits_v4 = scan.len >= 3'd1 && scan.len <= V4_MAX_LEN && scan.only_dec &&
			!(scan.len >= 3'd2 && scan.lead_zero) && scan.value < V4_LIMIT;
		fits_v6 = scan.len >= 3'd1 && scan.len <= V6_MAX_LEN && scan.only_hex;
		scan.v4_ok = scan.v4_ok && fits_v4;
		scan.v6_ok = scan.v6_ok && fits_v6;
		if (scan.groups != 4'hF) begin
			scan.groups = scan.groups + 4'd1;
		end
		start_group();
	endfunction

	function automatic void absorb_char(input logic [7:0] c);
		logic        is_dec;
		logic        is_hex;
		int unsigned acc;
		if (c == CH_COLON || c == CH_DOT) begin
			if (c == CH_COLON) begin
				scan.colon_seen = 1'b1;
			end else begin
				scan.dot_seen = 1'b1;
			end
			close_group();
			return;
		end
		is_dec = c >= CH_0 && c <= CH_9;
		is_hex = is_dec || (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF);
		if (scan.len == 3'd0) begin
			scan.lead_zero = (c == CH_0);
		end
		if (!is_dec) begin
			scan.only_dec = 1'b0;
		end
		if (!is_hex) begin
			scan.only_hex = 1'b0;
		end
		if (is_dec) begin
			// decimal value saturates at the top of its 10 bits
			acc = int'(scan.value) * 10 + int'(c) - int'(CH_0);
			scan.value = (acc > 1023) ? 10'd1023 : acc[9:0];
		end
		if (scan.len != 3'd7) begin
			scan.len = scan.len + 3'd1;
		end
	endfunction

	// returns 1 when the byte ends a string, with the verdict it earns
	function automatic bit classify_char(input logic [7:0] c, input logic fin,
			output verdict_t v);
		v = VERDICT_NONE;
		absorb_char(c);
		if (!fin) begin
			return 1'b0;
		end
		close_group();
		if (scan.dot_seen && !scan.colon_seen && scan.v4_ok && scan.groups == GROUPS_V4) begin
			v = VERDICT_V4;
		end else if (scan.colon_seen && !scan.dot_seen && scan.v6_ok &&
				scan.groups == GROUPS_V6) begin
			v = VERDICT_V6;
		end
		clear_scan();
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// channel monitor: predicts on each byte transaction, checks each verdict
	// ------------------------------------------------------------------

	always @(posedge clk) begin : watch_channels
		verdict_t want;
		verdict_t oldest;
		if (arst_n) begin
			if (chars_if.valid && chars_if.ready) begin
				if (classify_char(chars_if.char_code, chars_if.last_char, want)) begin
					pending_verdicts = {pending_verdicts, want};
				end
			end
			if (verdicts_if.valid && verdicts_if.ready) begin
				if (pending_verdicts.size() == 0) begin
					$error("verdict: expected none, actual %0d", verdicts_if.verdict);
					error_count++;
				end else begin
					oldest = pending_verdicts.pop_front();
					verdicts_checked++;
					if (verdicts_if.verdict !== oldest) begin
						$error("verdict: expected %0d, actual %0d", oldest,
							verdicts_if.verdict);
						error_count++;
					end else if (oldest == VERDICT_V4) begin
						v4_hits++;
					end else if (oldest == VERDICT_V6) begin
						v6_hits++;
					end
				end
			end
		end
	end

	// watchdog: any transaction on either side counts as progress
	always @(posedge clk) begin
		if (!arst_n || (chars_if.valid && chars_if.ready) ||
				(verdicts_if.valid && verdicts_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d verdicts outstanding",
				quiet_cycles, pending_verdicts.size());
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// verdict sink: back-pressure in random bursts while idling is on
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			verdicts_if.ready <= 1'b0;
			stall_left        <= $urandom_range(1, 7) - 1;
		end else begin
			verdicts_if.ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// byte source
	// ------------------------------------------------------------------

	// one byte transaction, with an optional gap in front of it
	task automatic send_char(input logic [7:0] c, input logic fin);
		int unsigned gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 7);
			chars_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_if.valid     <= 1'b1;
		chars_if.char_code <= c;
		chars_if.last_char <= fin;
		@(posedge clk);
		while (!chars_if.ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text();
		foreach (text_buf[i]) begin
			send_char(text_buf[i], i == text_buf.size() - 1);
		end
		strings_sent++;
	endtask

	// adds one byte at the end of the string under construction
	function automatic void append_char(input logic [7:0] c);
		text_buf = {text_buf, c};
	endfunction

	function automatic void load_text(input string s);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++) begin
			append_char(s[i]);
		end
	endfunction

	task automatic send_string(input string s);
		load_text(s);
		send_text();
	endtask

	// ------------------------------------------------------------------
	// random string builders
	// ------------------------------------------------------------------

	function automatic void push_decimal(input int unsigned v);
		if (v >= 100) begin
			append_char(8'(CH_0 + (v / 100) % 10));
		end
		if (v >= 10) begin
			append_char(8'(CH_0 + (v / 10) % 10));
		end
		append_char(8'(CH_0 + v % 10));
	endfunction

	function automatic logic [7:0] random_hex_char();
		int unsigned r;
		r = $urandom_range(0, 23);
		if (r < 10) begin
			return 8'(CH_0 + r);
		end else if (r < 16) begin
			return 8'(CH_LA + (r - 10));
		end else if (r < 22) begin
			return 8'(CH_UA + (r - 16));
		end
		// just past the hex letters
		return (r == 22) ? CH_LF + 8'd1 : CH_UF + 8'd1;
	endfunction

	// dotted quad, mostly well formed with random values
	function automatic void build_v4_text();
		int unsigned n_groups;
		text_buf.delete();
		n_groups = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 5) : 4;
		for (int g = 0; g < n_groups; g++) begin
			if (g != 0) begin
				append_char(CH_DOT);
			end
			case ($urandom_range(0, 11))
				0: push_decimal($urandom_range(256, 999));
				1: begin
					append_char(CH_0);
					push_decimal($urandom_range(0, 99));
				end
				2: push_decimal($urandom_range(0, 1) ? 255 : 0);
				3: if ($urandom_range(0, 2) == 0) begin
					// empty group
				end else begin
					push_decimal($urandom_range(0, 9));
				end
				default: push_decimal($urandom_range(0, 255));
			endcase
		end
	endfunction

	// eight hex groups, mostly well formed with random digits and case
	function automatic void build_v6_text();
		int unsigned n_groups;
		int unsigned glen;
		text_buf.delete();
		n_groups = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 9) : 8;
		for (int g = 0; g < n_groups; g++) begin
			if (g != 0) begin
				append_char(CH_COLON);
			end
			glen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : $urandom_range(1, 4);
			for (int k = 0; k < glen; k++) begin
				append_char(8'(($urandom_range(0, 15) == 0) ? random_hex_char() :
					(($urandom_range(0, 1) != 0) ? CH_0 + $urandom_range(0, 9) :
					CH_LA + $urandom_range(0, 5))));
			end
		end
	endfunction

	// short junk: digits, separators and arbitrary bytes
	function automatic void build_noise_text();
		int unsigned n;
		int unsigned r;
		text_buf.delete();
		n = $urandom_range(1, 12);
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 5);
			case (r)
				0: append_char(CH_DOT);
				1: append_char(CH_COLON);
				2, 3: append_char(random_hex_char());
				default: append_char(8'($urandom_range(0, 255)));
			endcase
		end
	endfunction

	// occasionally break a well formed string in one place
	function automatic void corrupt_text();
		int unsigned pos;
		if (text_buf.size() != 0 && $urandom_range(0, 5) == 0) begin
			pos = $urandom_range(0, text_buf.size() - 1);
			case ($urandom_range(0, 2))
				0: text_buf[pos] = 8'($urandom_range(0, 255));
				1: text_buf[pos] = (text_buf[pos] == CH_DOT) ? CH_COLON : CH_DOT;
				default: text_buf.delete(pos);
			endcase
			if (text_buf.size() == 0) begin
				append_char(8'($urandom_range(0, 255)));
			end
		end
	endfunction

	task automatic send_random_strings(input int unsigned budget, input bit vary_idle);
		int unsigned stop_at;
		stop_at = bytes_sent + budget;
		while (bytes_sent < stop_at) begin
			if (vary_idle) begin
				// mostly idling, with some runs at full rate
				idle_on = ($urandom_range(0, 3) != 0);
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: build_v4_text();
				4, 5, 6, 7: build_v6_text();
				default: build_noise_text();
			endcase
			corrupt_text();
			send_text();
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	task automatic test_ipv4_directed();
		send_string("192.168.1.1");
		send_string("0.0.0.0");
		send_string("255.255.255.255");
		send_string("0.10.100.199");
		send_string("256.0.0.1");
		send_string("01.2.3.4");
		send_string("001.1.1.1");
		send_string("1.2.3");
		send_string("1..2.3");
	endtask

	task automatic test_ipv6_directed();
		send_string("2001:0db8:85a3:0000:0000:8A2E:0370:7334");
		send_string("0:0:0:0:0:0:0:0");
		send_string("fFfF:Aa:b:c:D:e:F:9");
		send_string("1:2:3:4:5:6:7");
		send_string("12345:1:1:1:1:1:1:1");
		send_string("1:2:3:4:5:6:7:g");
	endtask

	task automatic test_malformed_directed();
		// final byte is a separator
		send_string("1.2.3.4.");
		send_string("1:2:3:4:5:6:7:8:");
		// both separator kinds, none, or a lone separator
		send_string("1.2.3:4");
		send_string("abc");
		send_string(".");
		// long group saturates length and value
		send_string("99999999.1.1.1");
		// more groups than the counter holds
		send_string("1.1.1.1.1.1.1.1.1.1.1.1.1.1.1.1.1.1.1");
		// control and non-ascii bytes inside a group
		load_text("1.2.3.4");
		text_buf[2] = 8'h00;
		send_text();
		load_text("7:7:7:7:7:7:7:7");
		text_buf[0] = 8'hFF;
		send_text();
		text_buf.delete();
		append_char(8'hFF);
		send_text();
	endtask

	task automatic test_random_mixed();
		send_random_strings(RANDOM_BYTES, 1'b1);
	endtask

	// full rate on both sides to close the run
	task automatic test_random_streaming();
		idle_on = 1'b0;
		send_random_strings(STREAMING_BYTES, 1'b0);
	endtask

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		idle_on           = 1'b1;
		stall_left        = 0;
		quiet_cycles      = 0;
		error_count       = 0;
		bytes_sent        = 0;
		strings_sent      = 0;
		verdicts_checked  = 0;
		v4_hits           = 0;
		v6_hits           = 0;
		chars_if.valid     = 1'b0;
		chars_if.char_code = 8'h00;
		chars_if.last_char = 1'b0;
		verdicts_if.ready  = 1'b1;
		clear_scan();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ipv4_directed();
		test_ipv6_directed();
		test_malformed_directed();
		test_random_mixed();
		test_random_streaming();

		// drain: every verdict in, then a wait for anything extra
		chars_if.valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d strings in %0d bytes, %0d verdicts compared",
			strings_sent, bytes_sent, verdicts_checked);
		$display("valid results seen: %0d dotted quads, %0d hex addresses", v4_hits, v6_hits);
		if (error_count == 0 && pending_verdicts.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
